// ===== rtl/core/lruc_pkg.sv =====
// Package for the LRU key-value cache: shared constants and operation codes.
`default_nettype none

package lruc_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/lruc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lruc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
// Top level of the fully associative key-value cache with least-recently-used replacement.
`default_nettype none

// Each request is a get or a put on a 32-bit key. The block scans all MAX_ENTRIES slots of
// the key memory through its single registered read port, whatever the capacity. It then
// updates the recency ranks and writes the key and value memories in the RESOLVE state,
// and loads the result into the output register in the DONE state. The input becomes
// ready in the same cycle as the result becomes valid, so a new request is accepted only
// after the previous one is through. A result that is still waiting in the output
// register holds the block until it is taken.
// The capacity register may be written at any time the block is idle; a value of zero
// acts as one and a value above MAX_ENTRIES acts as MAX_ENTRIES. Lowering the capacity
// below the current fill drops no entries; new keys then replace the least recent entry.
module lru_key_value_cache import lruc_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CAP_W-1:0]  i_cfg_data,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [63:0]       i_s_axis_tdata,  // key, write_value
    input  wire logic [0:0]        i_s_axis_tuser,  // action
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic      [63:0]       o_m_axis_tdata,  // read_value, evicted_key
    output logic      [1:0]        o_m_axis_tuser   // hit, evicted
);

    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AW   = IW;
    localparam int FW   = $clog2(MAX_ENTRIES + 1);
    localparam int CW   = (FW > CAP_W) ? FW : CAP_W;
    localparam int CNTW = IW + 1;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_RESOLVE = 4'b0100,
        ST_DONE    = 4'b1000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CAP_W-1:0]  r_capacity;
    logic              r_act;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_wval;
    logic [CNTW-1:0]   r_cnt;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    logic              r_found;
    logic [IW-1:0]     r_match_idx;
    logic [AW-1:0]     r_match_age;
    logic              r_free_found;
    logic [IW-1:0]     r_free_idx;
    logic              r_old_found;
    logic [IW-1:0]     r_old_idx;
    logic [AW-1:0]     r_old_age;
    logic [KEY_W-1:0]  r_old_key;
    logic              r_evict;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [AW-1:0]     r_age [MAX_ENTRIES];
    logic [FW-1:0]     r_fill;
    logic              r_out_valid;
    logic              r_out_hit;
    logic [VAL_W-1:0]  r_out_rd;
    logic              r_out_ev;
    logic [KEY_W-1:0]  r_out_evk;

    logic              w_accept;
    logic              w_scan_end;
    logic              w_out_load;
    logic [KEY_W-1:0]  w_key_rd;
    logic [VAL_W-1:0]  w_val_rd;
    logic [CW-1:0]     w_cap_ext;
    logic [CW-1:0]     w_max_ext;
    logic [CW-1:0]     w_eff_cap;
    logic [FW-1:0]     w_fill_m1;
    logic [AW-1:0]     w_age_tgt;
    logic              w_insert;
    logic              w_do_evict;
    logic              w_promote;
    logic [IW-1:0]     w_prom_idx;
    logic [AW-1:0]     w_prom_age;
    logic              w_key_we;
    logic [IW-1:0]     w_key_waddr;
    logic              w_val_we;
    logic [IW-1:0]     w_val_waddr;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_scan_end      = (r_state == ST_SCAN) && (r_cnt == CNTW'(MAX_ENTRIES));
    assign w_out_load      = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    assign w_cap_ext = CW'(r_capacity);
    assign w_max_ext = CW'(MAX_ENTRIES);
    assign w_eff_cap = (r_capacity == '0) ? CW'(1) :
                       ((w_cap_ext > w_max_ext) ? w_max_ext : w_cap_ext);
    assign w_fill_m1 = r_fill - FW'(1);
    assign w_age_tgt = w_fill_m1[AW-1:0];

    assign w_insert   = (r_act == ACT_PUT) && !r_found && r_free_found &&
                        (CW'(r_fill) < w_eff_cap);
    assign w_do_evict = (r_act == ACT_PUT) && !r_found && !w_insert && r_old_found;
    assign w_promote  = r_found || w_do_evict;
    assign w_prom_idx = r_found ? r_match_idx : r_old_idx;
    assign w_prom_age = r_found ? r_match_age : r_old_age;

    assign w_key_we    = (r_state == ST_RESOLVE) && (w_insert || w_do_evict);
    assign w_key_waddr = w_insert ? r_free_idx : r_old_idx;
    assign w_val_we    = (r_state == ST_RESOLVE) && (r_act == ACT_PUT) &&
                         (r_found || w_insert || w_do_evict);
    assign w_val_waddr = r_found ? r_match_idx : w_key_waddr;

    lruc_ram #(
        .WIDTH(KEY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_key_we),
        .i_wr_addr (w_key_waddr),
        .i_wr_data (r_key),
        .i_rd_addr (r_cnt[IW-1:0]),
        .o_rd_data (w_key_rd)
    );

    lruc_ram #(
        .WIDTH(VAL_W),
        .DEPTH(MAX_ENTRIES)
    ) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_val_we),
        .i_wr_addr (w_val_waddr),
        .i_wr_data (r_wval),
        .i_rd_addr (r_match_idx),
        .o_rd_data (w_val_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_capacity <= CAP_RESET;
            r_cmp_vld  <= 1'b0;
            r_cnt      <= '0;
            r_valid    <= '0;
            r_fill     <= '0;
            for (int j = 0; j < MAX_ENTRIES; j++) begin
                r_age[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (w_accept) begin
                r_cnt <= '0;
            end else if ((r_state == ST_SCAN) && !w_scan_end) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
            r_cmp_vld <= (r_state == ST_SCAN) && !w_scan_end;
            if (r_state == ST_RESOLVE) begin
                for (int j = 0; j < MAX_ENTRIES; j++) begin
                    if (w_promote) begin
                        if (IW'(j) == w_prom_idx) begin
                            r_age[j] <= '0;
                        end else if (r_valid[j] && (r_age[j] < w_prom_age)) begin
                            r_age[j] <= r_age[j] + AW'(1);
                        end
                    end else if (w_insert) begin
                        if (IW'(j) == r_free_idx) begin
                            r_age[j]   <= '0;
                            r_valid[j] <= 1'b1;
                        end else if (r_valid[j]) begin
                            r_age[j] <= r_age[j] + AW'(1);
                        end
                    end
                end
                if (w_insert) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_old_found  <= 1'b0;
        end else if (w_accept) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_old_found  <= 1'b0;
        end else if (r_cmp_vld) begin
            if (r_valid[r_cmp_idx] && (w_key_rd == r_key) && !r_found) begin
                r_found     <= 1'b1;
                r_match_idx <= r_cmp_idx;
                r_match_age <= r_age[r_cmp_idx];
            end
            if (!r_valid[r_cmp_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
            if (r_valid[r_cmp_idx] && (r_age[r_cmp_idx] == w_age_tgt) && !r_old_found) begin
                r_old_found <= 1'b1;
                r_old_idx   <= r_cmp_idx;
                r_old_age   <= r_age[r_cmp_idx];
                r_old_key   <= w_key_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act  <= i_s_axis_tuser[0];
            r_key  <= i_s_axis_tdata[31:0];
            r_wval <= i_s_axis_tdata[63:32];
        end
        r_cmp_idx <= r_cnt[IW-1:0];
        if (r_state == ST_RESOLVE) begin
            r_evict <= w_do_evict;
        end
        if (w_out_load) begin
            r_out_hit <= r_found;
            r_out_ev  <= r_evict;
            r_out_evk <= r_evict ? r_old_key : '0;
            if (r_act == ACT_GET) begin
                r_out_rd <= r_found ? w_val_rd : MISS_VALUE;
            end else begin
                r_out_rd <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_evk, r_out_rd};
    assign o_m_axis_tuser  = {r_out_ev, r_out_hit};

`ifndef SYNTHESIS
    a_fill_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_fill))
        else $error("fill count disagrees with the number of valid entries");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("input ready while a request is in flight");

    a_hit_excludes_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("a result reports both a hit and an eviction");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= MAX_ENTRIES)
        else $error("fill count exceeds the number of entries");
`endif

endmodule

`default_nettype wire
